// ===== rtl/frsm_pkg.sv =====
// ----------------------------------------------------------------------------
// frsm_pkg: shared types and constants of the frequency / RoCoF monitor
// Field widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frsm_pkg;

  localparam int unsigned CNT_W     = 16;  // period count
  localparam int unsigned FREQ_W    = 24;  // frequency in mHz
  localparam int unsigned ROC_W     = 32;  // rate of change in mHz/s
  localparam int unsigned CFG_W     = 16;  // widest config register
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROC_THR  = 1'b1;

  localparam logic [CFG_W-1:0] FREQ_THR_RESET = 16'd49000;
  localparam logic [CFG_W-1:0] ROC_THR_RESET  = 16'd5000;

  localparam logic [FREQ_W-1:0] FREQ_MAX    = 24'hFF_FFFF;
  localparam logic [ROC_W-1:0]  ROC_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ROC_W-1:0]  ROC_NEG_MAG = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ,
    ST_DIFF,
    ST_MUL,
    ST_ROC,
    ST_DONE
  } frsm_state_e;

endpackage

// ===== rtl/frequency_roc_stability_monitor_core.sv =====
// Steps: ST_FREQ divides for the frequency, ST_DIFF and ST_MUL form |freq - prev| *
//   sample rate, ST_ROC divides for the rate and ST_DONE loads the result; the first
//   item after reset skips the rate step. No new item is taken until that load. A single
//   restoring divider, one quotient bit per cycle, serves both the frequency and the rate division.
// Reset: asynchronous, active low; thresholds to 49000 mHz / 5000 mHz/s,
//   previous frequency cleared, next item treated as the first.
// ----------------------------------------------------------------------------
// frequency_roc_stability_monitor_core: reciprocal frequency meter with RoCoF
// Turns a period count into frequency (mHz) and rate of change (mHz/s), and
// flags under-frequency, excessive rate of change and instability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_roc_stability_monitor_core #(
  parameter int unsigned SampleRateHz = 16000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [frsm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [frsm_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [frsm_pkg::CNT_W-1:0]          period_count_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [frsm_pkg::FREQ_W-1:0]         frequency_mhz_o,
  output logic signed [frsm_pkg::ROC_W-1:0]   roc_mhz_per_s_o,
  output logic                                under_freq_o,
  output logic                                roc_alarm_o,
  output logic                                unstable_o
);

  localparam int unsigned FREQ_W = frsm_pkg::FREQ_W;
  localparam int unsigned ROC_W  = frsm_pkg::ROC_W;
  localparam int unsigned CNT_W  = frsm_pkg::CNT_W;
  localparam int unsigned CFG_W  = frsm_pkg::CFG_W;

  // Frequency numerator is SampleRateHz * 1000 (mHz scaling).
  localparam longint unsigned FreqNum = longint'(SampleRateHz) * 64'd1000;
  localparam int unsigned FreqNumW = $clog2(FreqNum + 64'd1);
  localparam int unsigned SrW      = $clog2(SampleRateHz + 1);
  // |freq - prev| fits the frequency width; times the sample rate
  localparam int unsigned ProdW    = FREQ_W + SrW;
  localparam int unsigned NumW     = (ProdW > FreqNumW) ? ProdW : FreqNumW;
  localparam int unsigned StepW    = $clog2(NumW + 1);

  // numerator left-aligned so the quotient comes out in the low FreqNumW bits
  localparam logic [NumW-1:0] FreqNumAligned = NumW'(FreqNum) << (NumW - FreqNumW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] freq_thr_q, freq_thr_d;
  logic [CFG_W-1:0] roc_thr_q, roc_thr_d;

  always_comb begin
    freq_thr_d = freq_thr_q;
    roc_thr_d  = roc_thr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frsm_pkg::CFG_FREQ_THR: freq_thr_d = cfg_wdata_i;
        frsm_pkg::CFG_ROC_THR:  roc_thr_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_thr_q <= frsm_pkg::FREQ_THR_RESET;
      roc_thr_q  <= frsm_pkg::ROC_THR_RESET;
    end else begin
      freq_thr_q <= freq_thr_d;
      roc_thr_q  <= roc_thr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  frsm_pkg::frsm_state_e state_q, state_d;

  logic              in_take;     // item accepted this cycle
  logic              out_free;    // output register can take a result
  logic              div_done;
  logic [NumW-1:0]   div_quot;
  logic              div_start;
  logic [NumW-1:0]   div_num;
  logic [StepW-1:0]  div_steps;

  logic              first_q;     // no result yet since reset
  logic [FREQ_W-1:0] prev_q;      // frequency of the last result
  logic [CNT_W-1:0]  count_q;
  logic [FREQ_W-1:0] freq_q;
  logic [FREQ_W-1:0] mag_q;       // |freq - prev|
  logic              neg_q;       // freq < prev
  logic [ROC_W-1:0]  roc_q;       // saturated rate, two's complement
  logic [ROC_W-1:0]  roc_mag_q;   // magnitude of the saturated rate

  assign in_stall_o = (state_q != frsm_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frsm_pkg::ST_IDLE: begin
        // a zero count is taken and dropped
        if (in_take && (period_count_i != '0)) state_d = frsm_pkg::ST_FREQ;
      end
      frsm_pkg::ST_FREQ: begin
        if (div_done) state_d = first_q ? frsm_pkg::ST_DONE : frsm_pkg::ST_DIFF;
      end
      frsm_pkg::ST_DIFF: state_d = frsm_pkg::ST_MUL;
      frsm_pkg::ST_MUL:  state_d = frsm_pkg::ST_ROC;
      frsm_pkg::ST_ROC: begin
        if (div_done) state_d = frsm_pkg::ST_DONE;
      end
      frsm_pkg::ST_DONE: begin
        if (out_free) state_d = frsm_pkg::ST_IDLE;
      end
      default: state_d = frsm_pkg::ST_IDLE;
    endcase
  end

  // multiplier: |diff| * sample rate, registered inside the divider on start
  logic [ProdW-1:0] prod;
  assign prod = ProdW'(mag_q) * ProdW'(SampleRateHz);

  // divider control
  always_comb begin
    div_start = 1'b0;
    div_num   = FreqNumAligned;
    div_steps = StepW'(FreqNumW);
    unique case (state_q)
      frsm_pkg::ST_IDLE: begin
        div_start = in_take && (period_count_i != '0);
      end
      frsm_pkg::ST_MUL: begin
        div_start = 1'b1;
        div_num   = NumW'(prod);
        div_steps = StepW'(NumW);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  frsm_div #(
    .NumW  (NumW),
    .StepW (StepW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (in_take ? period_count_i : count_q),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [63:0]       quot_wide;
  logic [FREQ_W-1:0] freq_sat;
  logic [ROC_W-1:0]  roc_mag_sat;

  assign quot_wide = 64'(div_quot);
  assign freq_sat  = (quot_wide > 64'(frsm_pkg::FREQ_MAX)) ? frsm_pkg::FREQ_MAX
                                                           : quot_wide[FREQ_W-1:0];

  // saturation bound differs by sign: 2^31-1 up, 2^31 down
  always_comb begin
    if (neg_q) begin
      roc_mag_sat = (quot_wide > 64'(frsm_pkg::ROC_NEG_MAG)) ? frsm_pkg::ROC_NEG_MAG
                                                            : quot_wide[ROC_W-1:0];
    end else begin
      roc_mag_sat = (quot_wide > 64'(frsm_pkg::ROC_POS_MAX)) ? frsm_pkg::ROC_POS_MAX
                                                            : quot_wide[ROC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      count_q <= period_count_i;
    end
    if ((state_q == frsm_pkg::ST_FREQ) && div_done) begin
      freq_q    <= freq_sat;
      roc_q     <= '0;
      roc_mag_q <= '0;
    end
    if (state_q == frsm_pkg::ST_DIFF) begin
      neg_q <= (freq_q < prev_q);
      mag_q <= (freq_q < prev_q) ? (prev_q - freq_q) : (freq_q - prev_q);
    end
    if ((state_q == frsm_pkg::ST_ROC) && div_done) begin
      roc_mag_q <= roc_mag_sat;
      roc_q     <= neg_q ? (ROC_W'(0) - roc_mag_sat) : roc_mag_sat;
    end
  end

  // state kept across items
  logic load_out;
  assign load_out = (state_q == frsm_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      prev_q  <= '0;
    end else if (load_out) begin
      first_q <= 1'b0;
      prev_q  <= freq_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic low_flag, high_flag;

  assign low_flag  = (freq_q < FREQ_W'(freq_thr_q));
  assign high_flag = (roc_mag_q > ROC_W'(roc_thr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      frequency_mhz_o <= freq_q;
      roc_mhz_per_s_o <= roc_q;
      under_freq_o    <= low_flag;
      roc_alarm_o     <= high_flag;
      unstable_o      <= low_flag | high_flag;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // divider only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == frsm_pkg::ST_FREQ) || (state_q == frsm_pkg::ST_ROC)))
    else $error("divider finished outside a wait state");

  // leaving the done state always presents a result
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frsm_pkg::ST_DONE) && out_free |=> out_valid_o)
    else $error("result lost on leaving done state");

  // a high-rate flag needs a non-zero rate
  a_flag_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && roc_alarm_o |-> (roc_mhz_per_s_o != '0))
    else $error("high rate flag with zero rate");

  // the first result after reset carries a zero rate
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && first_q |-> (roc_q == '0))
    else $error("first result with non-zero rate");

endmodule

// ===== rtl/frsm_div.sv =====
// ----------------------------------------------------------------------------
// frsm_div: shared restoring divider, one quotient bit per cycle
// Unsigned num / den over a caller-chosen number of steps; the numerator
// is expected left-aligned so that the quotient lands in the low bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frsm_div #(
  parameter int unsigned NumW  = 38,
  parameter int unsigned StepW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [NumW-1:0]              num_i,
  input  logic [frsm_pkg::CNT_W-1:0]   den_i,
  input  logic [StepW-1:0]             steps_i,
  output logic                         done_o,
  output logic [NumW-1:0]              quot_o
);

  localparam int unsigned DenW = frsm_pkg::CNT_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [NumW-1:0]   quo_q, quo_d;

  logic [DenW:0]     shifted;
  logic [DenW:0]     trial;
  logic              fits;

  assign shifted = {rem_q, quo_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[DenW-1:0] : shifted[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  // remainder never reaches the divisor while iterating
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  // a finished division leaves the unit idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

  // busy never outlives its step count
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with zero steps left");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for frequency_roc_stability_monitor_core
// Drives period counts through a valid/stall channel and checks every reading
// (frequency, rate of change and flags) against a cycle-free model of the
// meter. It runs several threshold settings, puts random idle bursts on both
// sides and holds the output off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SAMPLE_RATE_HZ = 16000;
  localparam int          RANDOM_PER_PHASE = 400;
  localparam int          NUM_PHASES = 5;
  localparam int          NUM_DIRECTED = 23;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          HOLD_CYCLES = 300;
  localparam longint      CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [frsm_pkg::FREQ_W-1:0]       freq_mhz;
    logic signed [frsm_pkg::ROC_W-1:0] roc;
    logic                              low_freq;
    logic                              high_roc;
    logic                              unstable;
  } reading_t;

  // Model of the meter plus the queue of readings still to come out
  class reading_scoreboard;
    logic [frsm_pkg::CFG_W-1:0]  freq_thr;
    logic [frsm_pkg::CFG_W-1:0]  roc_thr;
    logic [frsm_pkg::FREQ_W-1:0] last_freq;
    bit                          first_pending;
    reading_t                    expected_readings[$];
    int                          mismatches;
    int                          checked;
    int                          saturated;

    function new();
      freq_thr      = frsm_pkg::FREQ_THR_RESET;
      roc_thr       = frsm_pkg::ROC_THR_RESET;
      last_freq     = '0;
      first_pending = 1'b1;
      mismatches    = 0;
      checked       = 0;
      saturated     = 0;
    endfunction

    function void set_threshold(logic [frsm_pkg::CFG_IDX_W-1:0] idx,
                                logic [frsm_pkg::CFG_W-1:0] value);
      case (idx)
        frsm_pkg::CFG_FREQ_THR: freq_thr = value;
        frsm_pkg::CFG_ROC_THR:  roc_thr  = value;
        default: ;
      endcase
    endfunction

    // Works out the reading for one accepted count; a zero count gives none
    function void note_count(logic [frsm_pkg::CNT_W-1:0] count);
      longint   quot;
      longint   rate;
      longint   mag;
      reading_t rd;
      if (count == '0) return;
      quot = (longint'(SAMPLE_RATE_HZ) * 1000) / longint'(count);
      rd.freq_mhz = (quot > longint'(frsm_pkg::FREQ_MAX)) ? frsm_pkg::FREQ_MAX
                                                          : quot[frsm_pkg::FREQ_W-1:0];
      if (first_pending) begin
        rate = 0;
        first_pending = 1'b0;
      end else begin
        // signed division truncates toward zero
        rate = ((longint'(rd.freq_mhz) - longint'(last_freq)) * longint'(SAMPLE_RATE_HZ))
               / longint'(count);
        if (rate > 64'sd2147483647) begin
          rate = 64'sd2147483647;
          saturated++;
        end else if (rate < -64'sd2147483648) begin
          rate = -64'sd2147483648;
          saturated++;
        end
      end
      last_freq   = rd.freq_mhz;
      rd.roc      = rate[frsm_pkg::ROC_W-1:0];
      mag         = (rate < 0) ? -rate : rate;
      rd.low_freq = (rd.freq_mhz < frsm_pkg::FREQ_W'(freq_thr));
      rd.high_roc = (mag > longint'(roc_thr));
      rd.unstable = rd.low_freq | rd.high_roc;
      expected_readings.push_back(rd);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reading freq=%0d roc=%0d", $time, got.freq_mhz, got.roc);
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      if (got.freq_mhz !== want.freq_mhz || got.roc !== want.roc ||
          got.low_freq !== want.low_freq || got.high_roc !== want.high_roc ||
          got.unstable !== want.unstable) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp freq=%0d roc=%0d flags=%b%b%b",
                    " got freq=%0d roc=%0d flags=%b%b%b"},
                   $time, want.freq_mhz, want.roc, want.low_freq, want.high_roc,
                   want.unstable, got.freq_mhz, got.roc, got.low_freq, got.high_roc,
                   got.unstable);
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [frsm_pkg::CFG_IDX_W-1:0]     cfg_idx = frsm_pkg::CFG_FREQ_THR;
  logic [frsm_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [frsm_pkg::CNT_W-1:0]         period_count = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [frsm_pkg::FREQ_W-1:0]        frequency_mhz;
  logic signed [frsm_pkg::ROC_W-1:0]  roc_mhz_per_s;
  logic                               under_freq;
  logic                               roc_alarm;
  logic                               unstable;

  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;
  longint            cycles = 0;
  int                counts_sent = 0;
  int                zero_counts = 0;
  int                settings_used = 1;
  int                walk_count = 320;
  reading_scoreboard sb = new();

  frequency_roc_stability_monitor_core #(
    .SampleRateHz (SAMPLE_RATE_HZ)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .period_count_i  (period_count),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frequency_mhz_o (frequency_mhz),
    .roc_mhz_per_s_o (roc_mhz_per_s),
    .under_freq_o    (under_freq),
    .roc_alarm_o     (roc_alarm),
    .unstable_o      (unstable)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycles, sb.expected_readings.size());
      $display("[frequency_roc_stability_monitor_core] ERROR");
      $finish;
    end
  end

  // Result side: sample at the rising edge
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.freq_mhz = frequency_mhz;
      got.roc      = roc_mhz_per_s;
      got.low_freq = under_freq;
      got.high_roc = roc_alarm;
      got.unstable = unstable;
      sb.check_reading(got);
    end
  end

  // Receiver stall: short random bursts, plus one long hold-off on request
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left != 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one count and returns at the falling edge after it was taken
  task automatic send_count(input logic [frsm_pkg::CNT_W-1:0] count);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    period_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_count(count);
    counts_sent++;
    if (count == '0) zero_counts++;
    @(negedge clk);
  endtask

  // Drop valid, let the block drain, then leave time for any zero count in flight
  task automatic drain;
    in_valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_thresholds(input logic [frsm_pkg::CFG_W-1:0] freq_thr,
                                  input logic [frsm_pkg::CFG_W-1:0] roc_thr);
    cfg_we    <= 1'b1;
    cfg_idx   <= frsm_pkg::CFG_FREQ_THR;
    cfg_wdata <= freq_thr;
    @(negedge clk);
    cfg_idx   <= frsm_pkg::CFG_ROC_THR;
    cfg_wdata <= roc_thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_threshold(frsm_pkg::CFG_FREQ_THR, freq_thr);
    sb.set_threshold(frsm_pkg::CFG_ROC_THR, roc_thr);
    settings_used++;
  endtask

  // Mostly a slowly drifting mains period, with some wide and odd counts mixed in
  function automatic logic [frsm_pkg::CNT_W-1:0] pick_count();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      walk_count = walk_count + $urandom_range(0, 4) - 2;
      if (walk_count < 290) walk_count = 290;
      if (walk_count > 360) walk_count = 360;
      return frsm_pkg::CNT_W'(walk_count);
    end
    if (sel < 70) return frsm_pkg::CNT_W'($urandom_range(290, 360));
    if (sel < 80) return frsm_pkg::CNT_W'($urandom_range(100, 2000));
    if (sel < 90) return frsm_pkg::CNT_W'($urandom_range(0, 65535));
    if (sel < 95) return '0;
    return frsm_pkg::CNT_W'($urandom_range(1, 8));
  endfunction

  initial begin
    logic [frsm_pkg::CNT_W-1:0] directed[NUM_DIRECTED];
    logic [frsm_pkg::CFG_W-1:0] freq_thr_set[NUM_PHASES];
    logic [frsm_pkg::CFG_W-1:0] roc_thr_set[NUM_PHASES];
    directed     = '{16'd0, 16'd320, 16'd1, 16'd2, 16'd65535, 16'd1,
                     16'd0, 16'd65535, 16'd32768, 16'd320, 16'd321,
                     16'd326, 16'd327, 16'd319, 16'd360, 16'd290,
                     16'd16000, 16'd0, 16'd4, 16'd255, 16'd320,
                     16'd21845, 16'd43690};
    freq_thr_set = '{16'd0, 16'd65535, 16'd45000, 16'd50000, 16'd0};
    roc_thr_set  = '{16'd0, 16'd65535, 16'd100, 16'd50000, 16'd0};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part runs on the reset thresholds; it starts with a zero count
    // so the first real reading still has to show a zero rate
    foreach (directed[i]) send_count(directed[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == NUM_PHASES - 1) begin
        // last stretch: random thresholds, no idling on either side
        write_thresholds(frsm_pkg::CFG_W'($urandom_range(45000, 50000)),
                         frsm_pkg::CFG_W'($urandom_range(100, 50000)));
        idle_on = 1'b0;
      end else begin
        write_thresholds(freq_thr_set[ph], roc_thr_set[ph]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 1 && n == 20) hold_req = 1'b1;
        send_count(pick_count());
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (sb.expected_readings.size() != 0) begin
      sb.mismatches++;
      $display("%0d readings never arrived", sb.expected_readings.size());
    end
    $display("covered %0d period counts (%0d zero) over %0d threshold settings",
             counts_sent, zero_counts, settings_used);
    $display("checked %0d readings, %0d with a saturated rate, %0d mismatches",
             sb.checked, sb.saturated, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[frequency_roc_stability_monitor_core] OK");
    end else begin
      $display("[frequency_roc_stability_monitor_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/frsm_pkg.sv
rtl/frsm_div.sv
rtl/frequency_roc_stability_monitor_core.sv
tb/tb.sv
